// ----- design/brs_pkg.sv -----
`default_nettype none
package brs_pkg;

   localparam int STACK_DEPTH_DEFAULT = 8;
   localparam int COUNT_WIDTH = 4;
   localparam int COUNT_MAX = 15;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int LIMIT_WIDTH = 4;

   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 4'd6;
   localparam logic CSR_IDX_LIMIT = 1'b0;

   localparam logic [2:0] MODE_PUSH    = 3'd0;
   localparam logic [2:0] MODE_POP     = 3'd1;
   localparam logic [2:0] MODE_PEEK    = 3'd2;
   localparam logic [2:0] MODE_REPLACE = 3'd3;
   localparam logic [2:0] MODE_CLEAR   = 3'd4;
   localparam logic [2:0] MODE_STATUS  = 3'd5;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [1:0] STATUS_BADPOS = 2'd3;

   typedef struct packed {
      logic [2:0]  mode;
      logic [3:0]  position;
      logic [31:0] name_tag;
      logic [29:0] student_id;
      logic [15:0] major_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_name;
      logic [29:0] read_student;
      logic [15:0] read_major;
      logic [3:0]  entry_count;
      logic        is_full;
      logic        is_empty;
   } rsp_type;

   typedef struct packed {
      logic [31:0] name_tag;
      logic [29:0] student_id;
      logic [15:0] major_tag;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic load_req;
      logic execute;
      logic load_read;
   } cmd_type;

   typedef struct packed {
      logic peek_hit;
   } stat_type;

endpackage
`default_nettype wire

// ----- design/brs_ctrl.sv -----
`default_nettype none
module brs_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire brs_pkg::stat_type stat,
   output brs_pkg::cmd_type      cmd
);

   brs_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         brs_pkg::ST_IDLE: begin
            if (req_valid) state_in = brs_pkg::ST_EXEC;
         end
         brs_pkg::ST_EXEC: begin
            if (out_free) begin
               state_in = stat.peek_hit ? brs_pkg::ST_LOAD : brs_pkg::ST_IDLE;
            end
         end
         brs_pkg::ST_LOAD: begin
            state_in = brs_pkg::ST_IDLE;
         end
         default: begin
            state_in = brs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.load_req  = 1'b0;
      cmd.execute   = 1'b0;
      cmd.load_read = 1'b0;
      unique case (state_ff)
         brs_pkg::ST_IDLE: begin
            req_ready    = !reset;
            cmd.load_req = req_valid && !reset;
         end
         brs_pkg::ST_EXEC: begin
            cmd.execute = out_free;
         end
         brs_pkg::ST_LOAD: begin
            cmd.load_read = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) ||
                         (cmd.execute && !stat.peek_hit) || cmd.load_read;
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/brs_datapath.sv -----
`default_nettype none
module brs_datapath #(
   parameter int STACK_DEPTH = brs_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire brs_pkg::req_type                  req_data,
   input  wire logic [brs_pkg::LIMIT_WIDTH-1:0]   limit,
   input  wire brs_pkg::cmd_type                  cmd,
   output brs_pkg::stat_type                      stat,
   output brs_pkg::rsp_type                       rsp_data
);

   localparam int IDX_WIDTH = $clog2(STACK_DEPTH);
   localparam int CW = brs_pkg::COUNT_WIDTH;
   localparam logic [CW-1:0] LIMIT_CAP =
      CW'((STACK_DEPTH < brs_pkg::COUNT_MAX) ? STACK_DEPTH : brs_pkg::COUNT_MAX);

   brs_pkg::req_type   req_ff;
   brs_pkg::rsp_type   rsp_ff, rsp_in;
   brs_pkg::entry_type store_ff [STACK_DEPTH];
   brs_pkg::entry_type rd_ff;
   brs_pkg::entry_type wr_entry;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      lim;
   logic [CW-1:0]      slot_diff;
   logic [IDX_WIDTH-1:0] slot_idx, wr_idx;
   logic [1:0]         status;
   logic               wr_en;
   logic               peek_hit;

   always_comb begin
      if (limit == '0) begin
         lim = CW'(1);
      end else if (CW'(limit) > LIMIT_CAP) begin
         lim = LIMIT_CAP;
      end else begin
         lim = CW'(limit);
      end
   end

   assign slot_diff = count_ff - req_ff.position;
   assign slot_idx  = IDX_WIDTH'(slot_diff);
   assign wr_entry  = '{name_tag: req_ff.name_tag, student_id: req_ff.student_id,
                        major_tag: req_ff.major_tag};

   always_comb begin
      status   = brs_pkg::STATUS_OK;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_idx   = IDX_WIDTH'(count_ff);
      peek_hit = 1'b0;
      unique case (req_ff.mode)
         brs_pkg::MODE_PUSH: begin
            if (count_ff >= lim) begin
               status = brs_pkg::STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         brs_pkg::MODE_POP: begin
            if (count_ff == '0) begin
               status = brs_pkg::STATUS_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         brs_pkg::MODE_PEEK, brs_pkg::MODE_REPLACE: begin
            if (count_ff == '0) begin
               status = brs_pkg::STATUS_EMPTY;
            end else if (req_ff.position == '0 || req_ff.position > count_ff) begin
               status = brs_pkg::STATUS_BADPOS;
            end else if (req_ff.mode == brs_pkg::MODE_PEEK) begin
               peek_hit = 1'b1;
            end else begin
               wr_en  = 1'b1;
               wr_idx = slot_idx;
            end
         end
         brs_pkg::MODE_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   assign stat.peek_hit = peek_hit;

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.execute) begin
         rsp_in.status       = status;
         rsp_in.read_name    = '0;
         rsp_in.read_student = '0;
         rsp_in.read_major   = '0;
         rsp_in.entry_count  = count_in;
         rsp_in.is_full      = (count_in >= lim);
         rsp_in.is_empty     = (count_in == '0);
      end else if (cmd.load_read) begin
         rsp_in.read_name    = rd_ff.name_tag;
         rsp_in.read_student = rd_ff.student_id;
         rsp_in.read_major   = rd_ff.major_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_data;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && wr_en) store_ff[wr_idx] <= wr_entry;
      rd_ff <= store_ff[slot_idx];
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// ----- design/bounded_record_stack_top.sv -----
// rsp_valid rises after the req passes the EXEC state and the rsp_valid register, with the
// LOAD state in between for a peek that hits; EXEC waits while a held result is not taken.
// One operation at a time; LOAD covers the registered read port of the record memory.
// The rsp output register frees the controller once a result is registered.
// Reset (synchronous, active high) empties the stack, sets the limit register to 6
// and leaves the record memory contents undefined.
`default_nettype none
module bounded_record_stack_top #(
   parameter int STACK_DEPTH = brs_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire brs_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output brs_pkg::rsp_type                         rsp_data,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [brs_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  wire logic [brs_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [brs_pkg::CSR_DATA_WIDTH-1:0]       prdata,
   output logic                                     pready
);

   localparam int AW = brs_pkg::CSR_ADDR_WIDTH;

   logic [brs_pkg::LIMIT_WIDTH-1:0] limit_ff, limit_in;
   logic                            csr_hit;
   brs_pkg::cmd_type                cmd;
   brs_pkg::stat_type               stat;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[AW-1] == brs_pkg::CSR_IDX_LIMIT);
   assign limit_in = (psel && penable && pwrite && pready && csr_hit) ?
                     pwdata[brs_pkg::LIMIT_WIDTH-1:0] : limit_ff;
   assign prdata  = csr_hit ? brs_pkg::CSR_DATA_WIDTH'(limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= brs_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   brs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   brs_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .limit    (limit_ff),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// ----- design/brs_checker.sv -----
`default_nettype none
module brs_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire brs_pkg::rsp_type rsp_data
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken while an operation is in progress");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.is_empty == (rsp_data.entry_count == '0))
      else $error("is_empty disagrees with entry_count");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != brs_pkg::STATUS_OK |->
         rsp_data.read_name == '0 && rsp_data.read_student == '0 &&
         rsp_data.read_major == '0)
      else $error("read fields nonzero on a failed operation");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == brs_pkg::STATUS_FULL |->
         rsp_data.is_full && !rsp_data.is_empty)
      else $error("full status without is_full");

endmodule

bind bounded_record_stack_top brs_checker u_brs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
